// File: rtl/html_entity_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// HTML entity decoder assertion macros
// Implication checks on clk, turned off while rst is high.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_DECODER_UNIT_MACROS_SVH
`define HTML_ENTITY_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HED_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hed assertion failed");
// next-cycle implication
`define HED_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hed assertion failed");
`else
`define HED_ASSERT_IMP(label, ante, cons)
`define HED_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared constants and the result bundle of the HTML entity decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hed_pkg;

  localparam int CODE_BITS   = 31;
  localparam int MAX_RESULTS = 6;
  localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);

  // bytes produced by one input item, bytes[0] goes out first
  typedef struct packed {
    logic [COUNT_BITS-1:0]       count;
    logic [MAX_RESULTS-1:0][7:0] bytes;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/html_entity_decoder_unit.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_unit
// Byte-stream HTML entity and <br> decoder with UTF-8 output of numeric codes.
// ----------------------------------------------------------------------------
//  port group  dir  tdata          tuser  tlast
//  s_*         in   in_byte[7:0]   -      end_of_text
//  m_*         out  out_byte[7:0]  -      last_of_run
//
//  One input byte per cycle while nothing stalls; items pass the input
//  register, then the result buffer. An item yielding N bytes holds the
//  result buffer until all are taken; the input register takes one more item
//  meanwhile, then stalls. Items yielding no bytes never wait for the buffer.
//  rst is synchronous: clears both valid flags and the parse state.
// ----------------------------------------------------------------------------
`default_nettype none

module html_entity_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast
);

`include "html_entity_decoder_unit_macros.svh"

  logic                                        in_v;
  logic [7:0]                                  in_b;
  logic                                        in_last;
  logic                                        fire;
  logic                                        buf_free;
  logic                                        pop;
  logic [hed_pkg::COUNT_BITS-1:0]              rem;
  logic [hed_pkg::MAX_RESULTS-1:0][7:0]        ob;
  hed_pkg::result_t                            res;

  hed_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .in_byte     (in_b),
    .end_of_text (in_last),
    .res         (res)
  );

  assign m_tvalid = (rem != '0);
  assign m_tdata  = ob[0];
  assign m_tlast  = (rem == hed_pkg::COUNT_BITS'(1));
  assign pop      = m_tvalid && m_tready;
  assign buf_free = !m_tvalid || (pop && m_tlast);
  assign fire     = in_v && ((res.count == '0) || buf_free);
  assign s_tready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (fire) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_b    <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (fire && res.count != '0) begin
      rem <= res.count;
    end else if (pop) begin
      rem <= rem - hed_pkg::COUNT_BITS'(1);
    end
  end

  // result buffer drains from element 0
  always_ff @(posedge clk) begin
    if (fire && res.count != '0) begin
      ob <= res.bytes;
    end else if (pop) begin
      ob <= ob >> 8;
    end
  end

  `HED_ASSERT_IMP(a_no_overwrite, fire && res.count != '0, buf_free)
  `HED_ASSERT_IMP(a_rem_range, in_v || !in_v,
                  rem <= hed_pkg::COUNT_BITS'(hed_pkg::MAX_RESULTS))
  `HED_ASSERT_NXT(a_drain_empty, pop && m_tlast && !(fire && res.count != '0), !m_tvalid)
  `HED_ASSERT_NXT(a_hold_input, in_v && !fire, in_v && $stable(in_b) && $stable(in_last))

endmodule

`default_nettype wire

// File: rtl/hed_parser.sv
// ----------------------------------------------------------------------------
// hed_parser
// Parse state and the per-byte decode: names, tags, numeric codes, UTF-8.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [7:0]       in_byte,
  input  wire logic             end_of_text,
  output hed_pkg::result_t      res
);

  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_ENTITY   = 3'd1;
  localparam logic [2:0] MODE_NUMERIC  = 3'd2;
  localparam logic [2:0] MODE_TAG      = 3'd3;
  localparam logic [2:0] MODE_SKIP_ENT = 3'd4;
  localparam logic [2:0] MODE_SKIP_TAG = 3'd5;

  localparam int         ENT_COUNT = 5;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [hed_pkg::CODE_BITS-1:0] CODE_MAX = {hed_pkg::CODE_BITS{1'b1}};
  localparam int PROD_BITS = hed_pkg::CODE_BITS + 4;

  // name bytes, position 0 in the low byte
  function automatic logic [7:0] ent_name_byte(input logic [2:0] idx, input logic [2:0] p);
    logic [39:0] w;
    logic [39:0] sh;
    begin
      unique case (idx)
        3'd0:    w = {8'h00, 8'h00, ";", "t", "l"};
        3'd1:    w = {8'h00, 8'h00, ";", "t", "g"};
        3'd2:    w = {8'h00, ";", "p", "m", "a"};
        3'd3:    w = {";", "s", "o", "p", "a"};
        3'd4:    w = {";", "t", "o", "u", "q"};
        default: w = '0;
      endcase
      sh = w >> {p, 3'b000};
      return sh[7:0];
    end
  endfunction

  function automatic logic [2:0] ent_len(input logic [2:0] idx);
    unique case (idx)
      3'd0, 3'd1: return 3'd3;
      3'd2:       return 3'd4;
      3'd3, 3'd4: return 3'd5;
      default:    return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] ent_char(input logic [2:0] idx);
    unique case (idx)
      3'd0:    return 8'h3C;
      3'd1:    return 8'h3E;
      3'd2:    return 8'h26;
      3'd3:    return 8'h27;
      3'd4:    return 8'h22;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] tag_byte(input logic [2:0] p);
    unique case (p)
      3'd0:    return "b";
      3'd1:    return "r";
      3'd2:    return ">";
      default: return 8'h00;
    endcase
  endfunction

  logic [2:0]                   mode, mode_next;
  logic [2:0]                   pos, pos_next;
  logic [ENT_COUNT-1:0]         mask, mask_next;
  logic [hed_pkg::CODE_BITS-1:0] code, code_next;
  logic                         closed, closed_next;

  logic                         to_normal;
  logic [ENT_COUNT-1:0]         ent_hits;
  logic                         hit;
  logic [7:0]                   hit_char;
  logic [PROD_BITS-1:0]         prod;
  logic                         is_digit;
  logic [35:0]                  cx;
  hed_pkg::result_t             utf;

  assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);

  // code * 10 + digit, saturating
  assign prod = (PROD_BITS'(code) << 3) + (PROD_BITS'(code) << 1)
              + PROD_BITS'(in_byte - CH_ZERO);

  // UTF-8 encoding of the accumulated code
  assign cx = 36'(code);
  always_comb begin
    utf = '0;
    if (cx == 36'd0) begin
      utf.count = '0;
    end else if (cx < 36'h80) begin
      utf.count    = hed_pkg::COUNT_BITS'(1);
      utf.bytes[0] = cx[7:0];
    end else if (cx < 36'h800) begin
      utf.count    = hed_pkg::COUNT_BITS'(2);
      utf.bytes[0] = 8'hC0 | {3'b000, cx[10:6]};
      utf.bytes[1] = {2'b10, cx[5:0]};
    end else if (cx < 36'h10000) begin
      utf.count    = hed_pkg::COUNT_BITS'(3);
      utf.bytes[0] = 8'hE0 | {4'b0000, cx[15:12]};
      utf.bytes[1] = {2'b10, cx[11:6]};
      utf.bytes[2] = {2'b10, cx[5:0]};
    end else if (cx < 36'h200000) begin
      utf.count    = hed_pkg::COUNT_BITS'(4);
      utf.bytes[0] = 8'hF0 | {5'b00000, cx[20:18]};
      utf.bytes[1] = {2'b10, cx[17:12]};
      utf.bytes[2] = {2'b10, cx[11:6]};
      utf.bytes[3] = {2'b10, cx[5:0]};
    end else if (cx < 36'h4000000) begin
      utf.count    = hed_pkg::COUNT_BITS'(5);
      utf.bytes[0] = 8'hF8 | {6'b000000, cx[25:24]};
      utf.bytes[1] = {2'b10, cx[23:18]};
      utf.bytes[2] = {2'b10, cx[17:12]};
      utf.bytes[3] = {2'b10, cx[11:6]};
      utf.bytes[4] = {2'b10, cx[5:0]};
    end else begin
      utf.count    = hed_pkg::COUNT_BITS'(6);
      utf.bytes[0] = 8'hFC | {7'b0000000, cx[30]};
      utf.bytes[1] = {2'b10, cx[29:24]};
      utf.bytes[2] = {2'b10, cx[23:18]};
      utf.bytes[3] = {2'b10, cx[17:12]};
      utf.bytes[4] = {2'b10, cx[11:6]};
      utf.bytes[5] = {2'b10, cx[5:0]};
    end
  end

  // candidate name match at the current position
  always_comb begin
    ent_hits = '0;
    hit      = 1'b0;
    hit_char = 8'h00;
    for (int i = 0; i < ENT_COUNT; i++) begin
      if (mask[i] && (pos < ent_len(3'(i))) && (ent_name_byte(3'(i), pos) == in_byte)) begin
        ent_hits[i] = 1'b1;
        if (pos + 3'd1 == ent_len(3'(i))) begin
          hit      = 1'b1;
          hit_char = ent_char(3'(i));
        end
      end
    end
  end

  always_comb begin
    mode_next   = mode;
    pos_next    = pos;
    mask_next   = mask;
    code_next   = code;
    closed_next = closed;
    to_normal   = 1'b0;
    res         = '0;

    unique case (mode)
      MODE_ENTITY: begin
        if (pos == 3'd0 && in_byte == CH_HASH) begin
          mode_next   = MODE_NUMERIC;
          code_next   = '0;
          closed_next = 1'b0;
        end else if (hit) begin
          res.count    = hed_pkg::COUNT_BITS'(1);
          res.bytes[0] = hit_char;
          to_normal    = 1'b1;
        end else if (ent_hits == '0) begin
          if (in_byte == CH_SEMI) begin
            to_normal = 1'b1;
          end else begin
            mode_next = MODE_SKIP_ENT;
            pos_next  = 3'd0;
            mask_next = '0;
          end
        end else begin
          mask_next = ent_hits;
          pos_next  = pos + 3'd1;
        end
      end
      MODE_NUMERIC: begin
        if (in_byte == CH_SEMI) begin
          res       = utf;
          to_normal = 1'b1;
        end else if (!closed && is_digit) begin
          code_next = (prod > PROD_BITS'(CODE_MAX)) ? CODE_MAX
                                                    : prod[hed_pkg::CODE_BITS-1:0];
        end else begin
          closed_next = 1'b1;
        end
      end
      MODE_TAG: begin
        if (pos < 3'd3 && tag_byte(pos) == in_byte) begin
          if (pos == 3'd2) begin
            res.count    = hed_pkg::COUNT_BITS'(1);
            res.bytes[0] = CH_LF;
            to_normal    = 1'b1;
          end else begin
            pos_next = pos + 3'd1;
          end
        end else if (in_byte == CH_GT) begin
          to_normal = 1'b1;
        end else begin
          mode_next = MODE_SKIP_TAG;
          pos_next  = 3'd0;
        end
      end
      MODE_SKIP_ENT: begin
        if (in_byte == CH_SEMI) begin
          to_normal = 1'b1;
        end
      end
      MODE_SKIP_TAG: begin
        if (in_byte == CH_GT) begin
          to_normal = 1'b1;
        end
      end
      default: begin
        if (in_byte == CH_AMP) begin
          mode_next = MODE_ENTITY;
          pos_next  = 3'd0;
          mask_next = '1;
        end else if (in_byte == CH_LT) begin
          mode_next = MODE_TAG;
          pos_next  = 3'd0;
          mask_next = '0;
        end else begin
          res.count    = hed_pkg::COUNT_BITS'(1);
          res.bytes[0] = in_byte;
          to_normal    = 1'b1;
        end
      end
    endcase

    // end of text drops any open sequence
    if (to_normal || end_of_text) begin
      mode_next   = MODE_NORMAL;
      pos_next    = 3'd0;
      mask_next   = '0;
      code_next   = '0;
      closed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NORMAL;
      pos    <= 3'd0;
      mask   <= '0;
      code   <= '0;
      closed <= 1'b0;
    end else if (fire) begin
      mode   <= mode_next;
      pos    <= pos_next;
      mask   <= mask_next;
      code   <= code_next;
      closed <= closed_next;
    end
  end

endmodule

`default_nettype wire

// File: tb/html_entity_decoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// html_entity_decoder_unit_test
// Feeds HTML text byte streams into the entity decoder and checks every decoded
// item against a behavioral predictor. A short directed pass covers each entity
// form and the corner cases. A long random pass mixes plain bytes, entities,
// tags, numeric codes of every UTF-8 length, malformed and cut-off sequences.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module html_entity_decoder_unit_test;

  localparam int IDLE_PCT     = 21;
  localparam int RANDOM_ITEMS = 320;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 10;

  localparam logic [7:0] CH_AMP  = 8'h26, CH_LT   = 8'h3C, CH_GT = 8'h3E,
                         CH_SEMI = 8'h3B, CH_HASH = 8'h23, CH_NL = 8'h0A,
                         CH_ZERO = 8'h30, CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    PM_TEXT, PM_ENTITY, PM_NUMERIC, PM_TAG, PM_SKIP_ENT, PM_SKIP_TAG
  } parse_mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } decoded_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
  logic       s_tlast  = 1'b0;    // end_of_text
  logic       m_tready = 1'b0;
  logic       s_tready;
  logic       m_tvalid;
  logic [7:0] m_tdata;            // [7:0] out_byte
  logic       m_tlast;            // last_of_run

  html_entity_decoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // predictor state
  parse_mode_t                   pmode  = PM_TEXT;
  logic [2:0]                    mpos   = '0;
  logic [4:0]                    cand   = '0;
  logic [hed_pkg::CODE_BITS-1:0] code   = '0;
  logic                          closed = 1'b0;

  string      ent_name [5] = '{"lt;", "gt;", "amp;", "apos;", "quot;"};
  logic [7:0] ent_char [5] = '{"<", ">", "&", "'", "\""};
  string      tag_text     = "br>";

  decoded_t   decoded_q[$];
  decoded_t   head_d;
  logic [7:0] tok[$];
  bit         no_gaps = 1'b0;
  int         items_sent, results_seen, errors, quiet_cycles;
  int         n_named, n_tags, n_numeric, n_broken;

  function automatic void to_text();
    pmode  = PM_TEXT;
    mpos   = '0;
    cand   = '0;
    code   = '0;
    closed = 1'b0;
  endfunction

  // advance the parse state by one byte and queue the bytes it decodes to
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    logic [7:0]                    outs [hed_pkg::MAX_RESULTS];
    int                            n;
    int                            hit;
    int                            len;
    logic [4:0]                    still;
    logic [7:0]                    lead;
    logic [63:0]                   wide;
    logic [hed_pkg::CODE_BITS-1:0] c;
    decoded_t                      d;
    n     = 0;
    hit   = -1;
    still = '0;
    case (pmode)
      PM_ENTITY: begin
        if (mpos == 0 && b == CH_HASH) begin
          pmode  = PM_NUMERIC;
          code   = '0;
          closed = 1'b0;
        end else begin
          for (int i = 0; i < 5; i++) begin
            if (cand[i] && mpos < ent_name[i].len() && ent_name[i][mpos] == b) begin
              still[i] = 1'b1;
              if (mpos + 1 == ent_name[i].len()) hit = i;
            end
          end
          if (hit >= 0) begin
            outs[n] = ent_char[hit];
            n++;
            to_text();
          end else if (still == '0) begin
            if (b == CH_SEMI) begin
              to_text();
            end else begin
              pmode = PM_SKIP_ENT;
              mpos  = '0;
              cand  = '0;
            end
          end else begin
            cand = still;
            mpos = mpos + 3'd1;
          end
        end
      end
      PM_NUMERIC: begin
        if (b == CH_SEMI) begin
          if (code != 0) begin
            c = code;
            if (c < 'h80)           begin len = 1; lead = 8'h00; end
            else if (c < 'h800)     begin len = 2; lead = 8'hC0; end
            else if (c < 'h10000)   begin len = 3; lead = 8'hE0; end
            else if (c < 'h200000)  begin len = 4; lead = 8'hF0; end
            else if (c < 'h4000000) begin len = 5; lead = 8'hF8; end
            else                    begin len = 6; lead = 8'hFC; end
            for (int i = len - 1; i > 0; i--) begin
              outs[i] = {2'b10, c[5:0]};
              c = c >> 6;
            end
            outs[0] = lead | c[7:0];
            n = len;
          end
          to_text();
        end else if (!closed && b >= CH_ZERO && b <= CH_NINE) begin
          wide = 64'(code) * 64'd10 + 64'(b - CH_ZERO);
          // saturate at the widest code
          if (wide > (64'd1 << hed_pkg::CODE_BITS) - 1) code = '1;
          else code = wide[hed_pkg::CODE_BITS-1:0];
        end else begin
          closed = 1'b1;
        end
      end
      PM_TAG: begin
        if (mpos < 3 && tag_text[mpos] == b) begin
          if (mpos == 2) begin
            outs[n] = CH_NL;
            n++;
            to_text();
          end else begin
            mpos = mpos + 3'd1;
          end
        end else if (b == CH_GT) begin
          to_text();
        end else begin
          pmode = PM_SKIP_TAG;
          mpos  = '0;
        end
      end
      PM_SKIP_ENT: if (b == CH_SEMI) to_text();
      PM_SKIP_TAG: if (b == CH_GT) to_text();
      default: begin
        if (b == CH_AMP) begin
          pmode = PM_ENTITY;
          mpos  = '0;
          cand  = '1;
        end else if (b == CH_LT) begin
          pmode = PM_TAG;
          mpos  = '0;
          cand  = '0;
        end else begin
          to_text();
          outs[n] = b;
          n++;
        end
      end
    endcase
    if (eot) to_text();
    for (int i = 0; i < n; i++) begin
      d.out_byte    = outs[i];
      d.last_of_run = (i == n - 1);
      decoded_q     = {decoded_q, d};
    end
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send_item(input logic [7:0] b, input logic eot);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, eot);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic void put_text(input string s);
    foreach (s[k]) tok = {tok, s[k]};
  endfunction

  task automatic send_tok(input bit eot_end);
    foreach (tok[k]) send_item(tok[k], eot_end && k == tok.size() - 1);
    tok.delete();
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] stop);
    logic [7:0] r;
    do r = 8'($urandom_range(255)); while (r == stop);
    return r;
  endfunction

  // size 0: code zero, 1..6: UTF-8 length, 7: past the saturation point
  function automatic void put_numeric(input int size, input bit junk);
    logic [30:0] v;
    string       digits;
    string       junk_set;
    junk_set = " +-x./";
    v = '0;
    case (size)
      1: v = 31'($urandom_range('h7F, 1));
      2: v = 31'($urandom_range('h7FF, 'h80));
      3: v = 31'($urandom_range('hFFFF, 'h800));
      4: v = 31'($urandom_range('h1FFFFF, 'h10000));
      5: v = 31'($urandom_range('h3FFFFFF, 'h200000));
      6: v = 31'($urandom_range('h7FFFFFFF, 'h4000000));
      default: v = '0;
    endcase
    digits = $sformatf("%0d", v);
    if (size == 7) begin
      digits = "";
      repeat ($urandom_range(15, 11)) digits = {digits, $sformatf("%0d", $urandom_range(9))};
    end
    if ($urandom_range(9) == 0) digits = {"0", digits};
    if (size == 0 && $urandom_range(1)) digits = "";
    put_text("&#");
    put_text(digits);
    if (junk) begin
      tok = {tok, junk_set[$urandom_range(junk_set.len() - 1)]};
      put_text($sformatf("%0d", $urandom_range(999)));
    end
    tok = {tok, CH_SEMI};
  endfunction

  function automatic void put_bad_entity();
    string nm;
    nm = ent_name[$urandom_range(4)];
    tok = {tok, CH_AMP};
    for (int i = 0; i < $urandom_range(nm.len() - 1); i++) tok = {tok, nm[i]};
    // sometimes fail right on the ';'
    if ($urandom_range(3) != 0) begin
      tok = {tok, any_but(CH_SEMI)};
      repeat ($urandom_range(3)) tok = {tok, any_but(CH_SEMI)};
    end
    tok = {tok, CH_SEMI};
  endfunction

  function automatic void put_bad_tag();
    tok = {tok, CH_LT};
    if ($urandom_range(1)) begin
      if ($urandom_range(1)) put_text("b");
      else put_text("br");
    end
    if ($urandom_range(3) != 0) begin
      tok = {tok, any_but(CH_GT)};
      repeat ($urandom_range(3)) tok = {tok, any_but(CH_GT)};
    end
    tok = {tok, CH_GT};
  endfunction

  function automatic void put_named();
    put_text("&");
    put_text(ent_name[$urandom_range(4)]);
  endfunction

  task automatic test_plain_bytes();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item("A", 1'b0);
  endtask

  task automatic test_named_entities();
    put_text("&quot;");
    send_tok(1'b0);
    n_named++;
  endtask

  task automatic test_tags();
    put_text("<br>");
    send_tok(1'b0);
    n_tags++;
  endtask

  task automatic test_numeric_entities();
    put_text("&#;");
    send_tok(1'b0);
    put_text("&#128;");
    send_tok(1'b0);
    n_numeric += 2;
  endtask

  task automatic test_broken_sequences();
    put_text("&;");
    send_tok(1'b0);
    put_text("<b>");
    send_tok(1'b0);
    // text ends inside a numeric entity
    put_text("&#1");
    send_tok(1'b1);
    n_broken += 3;
  endtask

  task automatic test_random_text();
    int stop_at;
    int pick;
    int cut;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      no_gaps = (items_sent > stop_at - 220 && items_sent < stop_at - 140);
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_item(8'($urandom_range(255)), $urandom_range(19) == 0);
      end else if (pick < 45) begin
        put_named();
        n_named++;
        send_tok($urandom_range(19) == 0);
      end else if (pick < 52) begin
        put_text("<br>");
        n_tags++;
        send_tok($urandom_range(19) == 0);
      end else if (pick < 72) begin
        put_numeric($urandom_range(7), $urandom_range(4) == 0);
        n_numeric++;
        send_tok($urandom_range(19) == 0);
      end else if (pick < 82) begin
        put_bad_entity();
        n_broken++;
        send_tok(1'b0);
      end else if (pick < 90) begin
        put_bad_tag();
        n_broken++;
        send_tok(1'b0);
      end else begin
        // cut a sequence short and end the text there
        case ($urandom_range(3))
          0: put_numeric($urandom_range(7), 1'b0);
          1: put_named();
          2: put_bad_entity();
          default: put_bad_tag();
        endcase
        cut = $urandom_range(tok.size() - 1, 1);
        tok = tok[0:cut-1];
        n_broken++;
        send_tok(1'b1);
      end
    end
    no_gaps = 1'b0;
  endtask

  always @(negedge clk) begin
    m_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected item out_byte=%02h last_of_run=%0b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        head_d = decoded_q.pop_front();
        if (m_tdata !== head_d.out_byte) begin
          $display("%0t: out_byte expected %02h actual %02h",
                   $time, head_d.out_byte, m_tdata);
          errors++;
        end
        if (m_tlast !== head_d.last_of_run) begin
          $display("%0t: last_of_run expected %0b actual %0b",
                   $time, head_d.last_of_run, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d items still expected",
               $time, quiet_cycles, decoded_q.size());
      $display("html_entity_decoder_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_plain_bytes();
    test_named_entities();
    test_tags();
    test_numeric_entities();
    test_broken_sequences();
    test_random_text();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d text bytes in, %0d decoded bytes out; %0d named, %0d <br>, %0d numeric",
             items_sent, results_seen, n_named, n_tags, n_numeric);
    $display("%0d malformed or cut-off sequences, %0d mismatches", n_broken, errors);
    if (errors == 0) begin
      $display("html_entity_decoder_unit: match");
    end else begin
      $display("html_entity_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: html_entity_decoder_unit.f
+incdir+rtl
rtl/hed_pkg.sv
rtl/hed_parser.sv
rtl/html_entity_decoder_unit.sv
tb/html_entity_decoder_unit_test.sv
